/* design/bra_pkg.sv */
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the baseline RMS accumulator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned SampW  = 16;
  localparam int unsigned MeanW  = 35;
  localparam int unsigned RmsW   = 17;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] MODE_POWER = 2'd0;
  localparam logic [1:0] MODE_SQDIF = 2'd1;
  localparam logic [1:0] MODE_DIFF  = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  // one table entry: clean and all-sample statistics
  typedef struct packed {
    logic [CountW-1:0]      clean_count;
    logic signed [SumW-1:0] clean_sum;
    logic [CountW-1:0]      all_count;
    logic signed [SumW-1:0] all_sum;
  } entry_t;

  typedef enum logic [10:0] {
    S_CLR  = 11'b000_0000_0001,
    S_IDLE = 11'b000_0000_0010,
    S_RD   = 11'b000_0000_0100,
    S_MUL0 = 11'b000_0000_1000,
    S_MUL1 = 11'b000_0001_0000,
    S_WR   = 11'b000_0010_0000,
    S_LOAD = 11'b000_0100_0000,
    S_DIV  = 11'b000_1000_0000,
    S_FIN  = 11'b001_0000_0000,
    S_ROOT = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_e;

endpackage

/* design/bra_table.sv */
// ----------------------------------------------------------------------------
// bra_table
// Single write port, single registered read port statistics store.
// ----------------------------------------------------------------------------
module bra_table #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned AddrW = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  bra_pkg::entry_t   wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output bra_pkg::entry_t   rdata_o
);
  import bra_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/baseline_rms_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// baseline_rms_accumulator_unit
// Per-baseline sums and counts with mean / rms readout.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | content
//  in      | in        | in_valid_i / in_stall_o      | op, baseline, flag, sample, ref
//  out     | out       | out_valid_o / out_stall_i    | mean, rms, count, used_all
//  cfg     | in        | cfg_valid_i / cfg_ready_o    | accumulate_mode
//
//  Accumulate: RD, WR in difference-sum mode; RD, MUL0, MUL1, WR in the squaring
//  modes (one shared 17x17 multiplier, two products). Mode 3 / bad index: dropped
//  in IDLE. Read: RD, LOAD, the 64-step restoring divider (skipped for an empty
//  entry), FIN, the 18-step root and OUT. After reset a clearing pass writes all
//  MAX_ANTENNAS^2*MAX_FIELDS entries, during which in_stall_o is high.
//  A held result only delays the next read, which waits at its last step.
module baseline_rms_accumulator_unit #(
  parameter int unsigned MAX_ANTENNAS = 64,
  parameter int unsigned MAX_FIELDS   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [5:0]          antenna_a_i,
  input  logic [5:0]          antenna_b_i,
  input  logic [1:0]          field_number_i,
  input  logic                flagged_i,
  input  logic signed [15:0]  sample_re_i,
  input  logic signed [15:0]  sample_im_i,
  input  logic signed [15:0]  ref_re_i,
  input  logic signed [15:0]  ref_im_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [34:0]  mean_value_o,
  output logic [16:0]         rms_value_o,
  output logic [31:0]         value_count_o,
  output logic                used_all_samples_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);
  import bra_pkg::*;

  localparam int unsigned NumEntries = MAX_ANTENNAS * MAX_ANTENNAS * MAX_FIELDS;
  localparam int unsigned IdxW = (NumEntries > 1) ? $clog2(NumEntries) : 1;

  state_e state_q, state_d;

  logic [1:0] mode_q;
  logic [IdxW-1:0] clr_q, idx_q;
  logic op_q, flag_q;
  logic signed [16:0] x0_q, x1_q;
  logic signed [34:0] acc_q;

  // divider / root
  logic [63:0] dq_q;
  logic [32:0] rem_q;
  logic [31:0] div_q;
  logic [5:0]  dcnt_q;
  logic        neg_q;
  logic [35:0] rx_q, rres_q, rbit_q;
  logic [4:0]  rcnt_q;
  logic signed [34:0] mean_q;
  logic [31:0] cnt_q;
  logic        all_q;

  logic        out_valid_q;
  logic signed [34:0] out_mean_q;
  logic [16:0] out_rms_q;
  logic [31:0] out_cnt_q;
  logic        out_all_q;

  entry_t rdata, wdata;
  logic   we;
  logic [IdxW-1:0] waddr;

  // ---------------- input decode
  logic in_acc;
  logic idx_ok;
  logic [IdxW-1:0] idx_in;
  logic signed [16:0] dr, di;

  assign in_acc = in_valid_i && !in_stall_o;
  assign idx_ok = (32'(antenna_a_i) < 32'(MAX_ANTENNAS)) &&
                  (32'(antenna_b_i) < 32'(MAX_ANTENNAS)) &&
                  (32'(field_number_i) < 32'(MAX_FIELDS));
  assign idx_in = (IdxW'(field_number_i) * IdxW'(MAX_ANTENNAS) + IdxW'(antenna_b_i))
                  * IdxW'(MAX_ANTENNAS) + IdxW'(antenna_a_i);
  assign dr = 17'(ref_re_i) - 17'(sample_re_i);
  assign di = 17'(ref_im_i) - 17'(sample_im_i);

  // ---------------- shared multiplier
  logic signed [16:0] mul_a;
  logic signed [33:0] prod;
  assign mul_a = (state_q == S_MUL0) ? x0_q : x1_q;
  assign prod  = mul_a * mul_a;

  // ---------------- accumulate writeback
  logic signed [63:0] v;
  logic signed [63:0] new_all, new_clean;
  logic [31:0] new_all_cnt, new_clean_cnt;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] s,
                                                 logic signed [63:0] a);
    logic [64:0] t;
    t = {s[63], s} + {a[63], a};
    if (t[64] != t[63]) begin
      sat_add = t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = t[63:0];
    end
  endfunction

  function automatic logic [31:0] cnt_add2(logic [31:0] c);
    cnt_add2 = (c >= 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : c + 32'd2;
  endfunction

  assign v = (mode_q == MODE_DIFF) ? 64'(x0_q) + 64'(x1_q) : 64'(acc_q);
  assign new_all       = sat_add(rdata.all_sum, v);
  assign new_clean     = sat_add(rdata.clean_sum, v);
  assign new_all_cnt   = cnt_add2(rdata.all_count);
  assign new_clean_cnt = cnt_add2(rdata.clean_count);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = '0;
    if (state_q == S_CLR) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (state_q == S_WR) begin
      we                = 1'b1;
      wdata.all_sum     = new_all;
      wdata.all_count   = new_all_cnt;
      wdata.clean_sum   = flag_q ? rdata.clean_sum : new_clean;
      wdata.clean_count = flag_q ? rdata.clean_count : new_clean_cnt;
    end
  end

  bra_table #(
    .Depth (NumEntries),
    .AddrW (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (state_q == S_RD),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // ---------------- read path selection and step logic
  logic        sel_all;
  logic [31:0] sel_cnt;
  logic signed [63:0] sel_sum;
  assign sel_all = (rdata.clean_count == 32'd0);
  assign sel_cnt = sel_all ? rdata.all_count : rdata.clean_count;
  assign sel_sum = sel_all ? rdata.all_sum : rdata.clean_sum;

  logic [32:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q[31:0], dq_q[63]};
  assign rem_ge = rem_sh >= {1'b0, div_q};

  logic [35:0] rtry;
  assign rtry = rres_q + rbit_q;

  logic signed [34:0] mean_fin;
  always_comb begin
    if (neg_q) begin
      mean_fin = (dq_q > 64'h4_0000_0000) ? 35'sh4_0000_0000 : -$signed(dq_q[34:0]);
    end else begin
      mean_fin = (dq_q > 64'h3_FFFF_FFFF) ? 35'sh3_FFFF_FFFF : $signed(dq_q[34:0]);
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == IdxW'(NumEntries - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_READ) begin
            state_d = idx_ok ? S_RD : S_OUT;
          end else if (!idx_ok || mode_q == MODE_OFF) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (op_q == OP_READ)         state_d = S_LOAD;
        else if (mode_q == MODE_DIFF) state_d = S_WR;
        else                         state_d = S_MUL0;
      end
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_WR;
      S_WR:   state_d = S_IDLE;
      S_LOAD: state_d = (sel_cnt == 32'd0) ? S_FIN : S_DIV;
      S_DIV:  if (dcnt_q == 6'd63) state_d = S_FIN;
      S_FIN:  state_d = S_ROOT;
      S_ROOT: if (rcnt_q == 5'd17) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      mode_q      <= MODE_POWER;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + IdxW'(1);
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q   <= op_i;
        idx_q  <= idx_in;
        flag_q <= flagged_i;
        if (mode_q == MODE_POWER) begin
          x0_q <= 17'(sample_re_i);
          x1_q <= 17'(sample_im_i);
        end else begin
          x0_q <= dr;
          x1_q <= di;
        end
        // out-of-range read reports all zero
        mean_q <= '0;
        rres_q <= '0;
        cnt_q  <= '0;
        all_q  <= 1'b0;
      end
      S_MUL0: acc_q <= 35'(prod);
      S_MUL1: acc_q <= acc_q + 35'(prod);
      S_LOAD: begin
        cnt_q  <= sel_cnt;
        all_q  <= sel_all;
        div_q  <= sel_cnt;
        // empty entry goes straight to the root with a zero mean
        neg_q  <= (sel_cnt == 32'd0) ? 1'b0 : sel_sum[63];
        dq_q   <= (sel_cnt == 32'd0) ? 64'd0 :
                  sel_sum[63] ? 64'(-sel_sum) : 64'(sel_sum);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      S_DIV: begin
        dcnt_q <= dcnt_q + 6'd1;
        dq_q   <= {dq_q[62:0], rem_ge};
        rem_q  <= rem_ge ? rem_sh - {1'b0, div_q} : rem_sh;
      end
      S_FIN: begin
        mean_q <= mean_fin;
        rx_q   <= mean_fin[34] ? 36'd0 : 36'(mean_fin);
        rres_q <= '0;
        rbit_q <= 36'h4_0000_0000;
        rcnt_q <= '0;
      end
      S_ROOT: begin
        rcnt_q <= rcnt_q + 5'd1;
        rbit_q <= rbit_q >> 2;
        if (rx_q >= rtry) begin
          rx_q   <= rx_q - rtry;
          rres_q <= (rres_q >> 1) + rbit_q;
        end else begin
          rres_q <= rres_q >> 1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_mean_q <= mean_q;
      out_rms_q  <= rres_q[16:0];
      out_cnt_q  <= cnt_q;
      out_all_q  <= all_q;
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign mean_value_o       = out_mean_q;
  assign rms_value_o        = out_rms_q;
  assign value_count_o      = out_cnt_q;
  assign used_all_samples_o = out_all_q;

  // ---------------- assertions
  a_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> in_stall_o)
    else $error("request accepted during clearing pass");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> out_valid_o)
    else $error("result lost at output register");

  a_wr_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> op_q == OP_ACC)
    else $error("table write on a read request");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && dcnt_q != 6'd63) |=> state_q == S_DIV)
    else $error("divider left early");

endmodule
